// ----- rtl/lttl_pkg.sv -----
package lttl_pkg;

  localparam int KEY_BITS      = 64;
  localparam int VALUE_BITS    = 64;
  localparam int TIME_BITS     = 40;
  localparam int LIFETIME_BITS = 24;
  localparam int COUNT_BITS    = 32;
  localparam int CAP_BITS      = 5;
  localparam int CFG_BITS      = 24;

  localparam logic [2:0] OP_GET    = 3'd0;
  localparam logic [2:0] OP_SET    = 3'd1;
  localparam logic [2:0] OP_DELETE = 3'd2;
  localparam logic [2:0] OP_EXISTS = 3'd3;
  localparam logic [2:0] OP_CLEAN  = 3'd4;
  localparam logic [2:0] OP_TICK   = 3'd5;

  localparam logic CFG_CAPACITY = 1'b0;
  localparam logic CFG_DEF_TTL  = 1'b1;

  localparam logic [CAP_BITS-1:0]      CAP_RESET = 5'd16;
  localparam logic [LIFETIME_BITS-1:0] TTL_RESET = 24'd86400;

  typedef struct packed {
    logic [2:0]               op;
    logic [KEY_BITS-1:0]      key;
    logic [VALUE_BITS-1:0]    value;
    logic [LIFETIME_BITS-1:0] ttl;
  } req_t;

  typedef struct packed {
    logic valid;
    req_t req;
  } queue_head_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOK,
    ST_EXEC,
    ST_EVICT,
    ST_CLEAN,
    ST_DONE
  } state_t;

endpackage

// ----- rtl/lru_ttl_key_value_cache.sv -----
// channel | ports                                   | direction
// request | in_valid in_stall in_opcode in_lookup_key in_write_value in_lifetime | in
// result  | out_valid out_stall out_found out_read_value out_entry_count
//         | out_hit_count out_miss_count            | out
// config  | cfg_we cfg_index cfg_data               | in
// get, delete, exists, tick: look, execute, done, then the result register
// set: look, execute (repeated after a full-store eviction), evict to capacity, done
// cleanup: look, execute, a scan of every slot, then done
// a two-deep request queue takes requests while a result waits under stall
// synchronous active-low reset empties the store and clears time and counters
module lru_ttl_key_value_cache #(
  parameter int ENTRIES = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [2:0]                          in_opcode,
  input  logic [lttl_pkg::KEY_BITS-1:0]       in_lookup_key,
  input  logic [lttl_pkg::VALUE_BITS-1:0]     in_write_value,
  input  logic [lttl_pkg::LIFETIME_BITS-1:0]  in_lifetime,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_found,
  output logic [lttl_pkg::VALUE_BITS-1:0]     out_read_value,
  output logic [4:0]                          out_entry_count,
  output logic [lttl_pkg::COUNT_BITS-1:0]     out_hit_count,
  output logic [lttl_pkg::COUNT_BITS-1:0]     out_miss_count,
  input  logic                                cfg_we,
  input  logic                                cfg_index,
  input  logic [lttl_pkg::CFG_BITS-1:0]       cfg_data
);
  import lttl_pkg::*;

  logic [CAP_BITS-1:0]      cap_r;
  logic [LIFETIME_BITS-1:0] ttl_r;
  queue_head_t              head;
  logic                     pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
      ttl_r <= TTL_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CAPACITY: cap_r <= cfg_data[CAP_BITS-1:0];
        CFG_DEF_TTL:  ttl_r <= cfg_data[LIFETIME_BITS-1:0];
        default: ;
      endcase
    end
  end

  lttl_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_opcode      (in_opcode),
    .in_lookup_key  (in_lookup_key),
    .in_write_value (in_write_value),
    .in_lifetime    (in_lifetime),
    .default_ttl    (ttl_r),
    .head           (head),
    .pop            (pop)
  );

  lttl_back #(.ENTRIES(ENTRIES)) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head            (head),
    .pop             (pop),
    .capacity        (cap_r),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_found       (out_found),
    .out_read_value  (out_read_value),
    .out_entry_count (out_entry_count),
    .out_hit_count   (out_hit_count),
    .out_miss_count  (out_miss_count)
  );

`ifndef SYNTHESIS
  a_hits_mono: assert property (@(posedge clk) disable iff (!rst_n)
    out_hit_count >= $past(out_hit_count)) else $error("hit count went down");
  a_miss_mono: assert property (@(posedge clk) disable iff (!rst_n)
    out_miss_count >= $past(out_miss_count)) else $error("miss count went down");
  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> 32'(out_entry_count) <= 32'(ENTRIES)) else $error("entry count too big");
`endif

endmodule

// ----- rtl/lttl_front.sv -----
module lttl_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [2:0]                        in_opcode,
  input  logic [lttl_pkg::KEY_BITS-1:0]     in_lookup_key,
  input  logic [lttl_pkg::VALUE_BITS-1:0]   in_write_value,
  input  logic [lttl_pkg::LIFETIME_BITS-1:0] in_lifetime,
  input  logic [lttl_pkg::LIFETIME_BITS-1:0] default_ttl,
  output lttl_pkg::queue_head_t             head,
  input  logic                              pop
);
  import lttl_pkg::*;

  req_t       slot_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] level_r;
  logic       push;
  logic       do_pop;
  req_t       req;

  always_comb begin
    req.op    = in_opcode;
    req.key   = in_lookup_key;
    req.value = in_write_value;
    req.ttl   = (in_lifetime == '0) ? default_ttl : in_lifetime;
  end

  assign in_stall   = (level_r == 2'd2);
  assign push       = in_valid && !in_stall;
  assign do_pop     = pop && (level_r != 2'd0);
  assign head.valid = (level_r != 2'd0);
  assign head.req   = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= req;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      level_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (do_pop) rd_ptr_r <= !rd_ptr_r;
      level_r <= level_r + 2'(push) - 2'(do_pop);
    end
  end

endmodule

// ----- rtl/lttl_back.sv -----
module lttl_back #(
  parameter int ENTRIES = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  lttl_pkg::queue_head_t             head,
  output logic                              pop,
  input  logic [lttl_pkg::CAP_BITS-1:0]     capacity,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_found,
  output logic [lttl_pkg::VALUE_BITS-1:0]   out_read_value,
  output logic [4:0]                        out_entry_count,
  output logic [lttl_pkg::COUNT_BITS-1:0]   out_hit_count,
  output logic [lttl_pkg::COUNT_BITS-1:0]   out_miss_count
);
  import lttl_pkg::*;

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);

  state_t                state_r, state_nxt;
  req_t                  req_r;
  logic [ENTRIES-1:0]    valid_r;
  logic [KEY_BITS-1:0]   key_r   [ENTRIES];
  logic [VALUE_BITS-1:0] val_r   [ENTRIES];
  logic [TIME_BITS-1:0]  exp_r   [ENTRIES];
  logic [IW-1:0]         rank_r  [ENTRIES];
  logic [CW-1:0]         count_r;
  logic [TIME_BITS-1:0]  time_r;
  logic [COUNT_BITS-1:0] hits_r, miss_r;
  logic                  hit_r, live_r;
  logic [IW-1:0]         idx_r, scan_r;
  logic                  found_r;
  logic [VALUE_BITS-1:0] rv_r;

  logic [IW-1:0]         match_idx, free_idx, old_idx;
  logic                  match_any;
  logic [TIME_BITS:0]    exp_sum;
  logic [TIME_BITS-1:0]  exp_new;
  logic                  full, over_cap, last_scan, out_free;

  always_comb begin
    match_idx = '0;
    match_any = 1'b0;
    old_idx   = '0;
    free_idx  = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (valid_r[i] && key_r[i] == req_r.key) begin
        match_idx = match_idx | IW'(i);
        match_any = 1'b1;
      end
      if (valid_r[i] && rank_r[i] == IW'(count_r - CW'(1))) old_idx = old_idx | IW'(i);
    end
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (!valid_r[i]) free_idx = IW'(i);
    end
  end

  assign exp_sum   = {1'b0, time_r} + (TIME_BITS + 1)'(req_r.ttl);
  assign exp_new   = exp_sum[TIME_BITS] ? '1 : exp_sum[TIME_BITS-1:0];
  assign full      = (count_r == CW'(ENTRIES));
  assign over_cap  = (32'(count_r) > 32'(capacity));
  assign last_scan = (scan_r == IW'(ENTRIES - 1));
  assign out_free  = !out_valid || !out_stall;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (head.valid) state_nxt = ST_LOOK;
      ST_LOOK:  state_nxt = ST_EXEC;
      ST_EXEC: begin
        case (req_r.op)
          OP_SET:   state_nxt = (!hit_r && full) ? ST_EXEC : ST_EVICT;
          OP_CLEAN: state_nxt = ST_CLEAN;
          default:  state_nxt = ST_DONE;
        endcase
      end
      ST_EVICT: if (!over_cap) state_nxt = ST_DONE;
      ST_CLEAN: if (last_scan) state_nxt = ST_DONE;
      ST_DONE:  if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    pop = (state_r == ST_IDLE) && head.valid;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= ST_IDLE;
      valid_r         <= '0;
      count_r         <= '0;
      time_r          <= '0;
      hits_r          <= '0;
      miss_r          <= '0;
      out_valid       <= 1'b0;
      out_found       <= 1'b0;
      out_read_value  <= '0;
      out_entry_count <= '0;
      out_hit_count   <= '0;
      out_miss_count  <= '0;
    end else begin
      state_r <= state_nxt;
      if (out_valid && !out_stall && (state_r != ST_DONE)) out_valid <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (head.valid) req_r <= head.req;
          found_r <= 1'b0;
          rv_r    <= '0;
          scan_r  <= '0;
        end
        ST_LOOK: begin
          hit_r  <= match_any;
          idx_r  <= match_idx;
          live_r <= exp_r[match_idx] >= time_r;
        end
        ST_EXEC: begin
          case (req_r.op)
            OP_GET: begin
              if (hit_r && live_r) begin
                for (int i = 0; i < ENTRIES; i++)
                  if (valid_r[i] && rank_r[i] < rank_r[idx_r]) rank_r[i] <= rank_r[i] + 1'b1;
                rank_r[idx_r] <= '0;
                found_r <= 1'b1;
                rv_r    <= val_r[idx_r];
                if (hits_r != '1) hits_r <= hits_r + 1'b1;
              end else if (miss_r != '1) begin
                miss_r <= miss_r + 1'b1;
              end
            end
            OP_SET: begin
              if (hit_r) begin
                for (int i = 0; i < ENTRIES; i++)
                  if (valid_r[i] && rank_r[i] < rank_r[idx_r]) rank_r[i] <= rank_r[i] + 1'b1;
                rank_r[idx_r] <= '0;
                val_r[idx_r]  <= req_r.value;
                exp_r[idx_r]  <= exp_new;
              end else if (full) begin
                valid_r[old_idx] <= 1'b0;
                count_r <= count_r - 1'b1;
              end else begin
                for (int i = 0; i < ENTRIES; i++)
                  if (valid_r[i]) rank_r[i] <= rank_r[i] + 1'b1;
                valid_r[free_idx] <= 1'b1;
                rank_r[free_idx]  <= '0;
                key_r[free_idx]   <= req_r.key;
                val_r[free_idx]   <= req_r.value;
                exp_r[free_idx]   <= exp_new;
                count_r <= count_r + 1'b1;
              end
            end
            OP_DELETE: begin
              if (hit_r) begin
                valid_r[idx_r] <= 1'b0;
                count_r <= count_r - 1'b1;
                for (int i = 0; i < ENTRIES; i++)
                  if (valid_r[i] && rank_r[i] > rank_r[idx_r]) rank_r[i] <= rank_r[i] - 1'b1;
              end
            end
            OP_EXISTS: found_r <= hit_r && live_r;
            OP_TICK:   if (time_r != '1) time_r <= time_r + 1'b1;
            default: ;
          endcase
        end
        ST_EVICT: begin
          if (over_cap) begin
            valid_r[old_idx] <= 1'b0;
            count_r <= count_r - 1'b1;
          end
        end
        ST_CLEAN: begin
          if (valid_r[scan_r] && exp_r[scan_r] < time_r) begin
            valid_r[scan_r] <= 1'b0;
            count_r <= count_r - 1'b1;
            for (int i = 0; i < ENTRIES; i++)
              if (valid_r[i] && rank_r[i] > rank_r[scan_r]) rank_r[i] <= rank_r[i] - 1'b1;
          end
          scan_r <= scan_r + 1'b1;
        end
        ST_DONE: begin
          if (out_free) begin
            out_valid       <= 1'b1;
            out_found       <= found_r;
            out_read_value  <= rv_r;
            out_entry_count <= 5'(count_r);
            out_hit_count   <= hits_r;
            out_miss_count  <= miss_r;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
  import lttl_pkg::*;

  localparam int SLOTS = 16;
  localparam logic [TIME_BITS-1:0] TIME_MAX = '1;
  localparam logic [2:0] OP_SPARE6 = 3'd6;
  localparam logic [2:0] OP_SPARE7 = 3'd7;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    logic                    found;
    logic [VALUE_BITS-1:0]   value;
    logic [4:0]              count;
    logic [COUNT_BITS-1:0]   hits;
    logic [COUNT_BITS-1:0]   misses;
  } reply_t;

  typedef struct {
    logic [2:0]               op;
    logic [KEY_BITS-1:0]      key;
    logic [VALUE_BITS-1:0]    value;
    logic [LIFETIME_BITS-1:0] ttl;
    logic                     check_found;
    logic                     found;
    logic [VALUE_BITS-1:0]    rvalue;
  } step_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0] in_opcode = '0;
  logic [KEY_BITS-1:0] in_lookup_key = '0;
  logic [VALUE_BITS-1:0] in_write_value = '0;
  logic [LIFETIME_BITS-1:0] in_lifetime = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_found;
  logic [VALUE_BITS-1:0] out_read_value;
  logic [4:0] out_entry_count;
  logic [COUNT_BITS-1:0] out_hit_count;
  logic [COUNT_BITS-1:0] out_miss_count;
  logic cfg_we = 1'b0;
  logic cfg_index = 1'b0;
  logic [CFG_BITS-1:0] cfg_data = '0;

  lru_ttl_key_value_cache u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_opcode(in_opcode),
    .in_lookup_key(in_lookup_key), .in_write_value(in_write_value),
    .in_lifetime(in_lifetime),
    .out_valid(out_valid), .out_stall(out_stall), .out_found(out_found),
    .out_read_value(out_read_value), .out_entry_count(out_entry_count),
    .out_hit_count(out_hit_count), .out_miss_count(out_miss_count),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // cache shadow
  logic                    sh_valid [SLOTS];
  logic [KEY_BITS-1:0]     sh_key [SLOTS];
  logic [VALUE_BITS-1:0]   sh_value [SLOTS];
  logic [TIME_BITS-1:0]    sh_expiry [SLOTS];
  int unsigned             sh_rank [SLOTS];
  logic [TIME_BITS-1:0]    sh_now;
  logic [COUNT_BITS-1:0]   sh_hits, sh_misses;
  logic [CAP_BITS-1:0]     sh_capacity;
  logic [LIFETIME_BITS-1:0] sh_def_ttl;

  reply_t expected_replies[$];
  int mismatches = 0;
  bit failed = 0;
  int idle_cycles = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;
  bit hold_off = 0;
  logic [KEY_BITS-1:0] key_pool [8];

  function automatic int held();
    int n = 0;
    for (int i = 0; i < SLOTS; i++) if (sh_valid[i]) n++;
    return n;
  endfunction

  function automatic int lookup(logic [KEY_BITS-1:0] k);
    for (int i = 0; i < SLOTS; i++) if (sh_valid[i] && sh_key[i] == k) return i;
    return -1;
  endfunction

  function automatic void drop_slot(int s);
    int unsigned r;
    r = sh_rank[s];
    sh_valid[s] = 1'b0;
    for (int i = 0; i < SLOTS; i++) if (sh_valid[i] && sh_rank[i] > r) sh_rank[i]--;
  endfunction

  function automatic void promote(int s);
    int unsigned r;
    r = sh_rank[s];
    for (int i = 0; i < SLOTS; i++) if (sh_valid[i] && sh_rank[i] < r) sh_rank[i]++;
    sh_rank[s] = 0;
  endfunction

  function automatic void drop_oldest();
    int pick = -1;
    for (int i = 0; i < SLOTS; i++)
      if (sh_valid[i] && (pick < 0 || sh_rank[i] > sh_rank[pick])) pick = i;
    if (pick >= 0) drop_slot(pick);
  endfunction

  function automatic logic [TIME_BITS-1:0] add_time(logic [TIME_BITS-1:0] a,
                                                    logic [LIFETIME_BITS-1:0] b);
    logic [TIME_BITS:0] t;
    t = {1'b0, a} + (TIME_BITS + 1)'(b);
    return t[TIME_BITS] ? TIME_MAX : t[TIME_BITS-1:0];
  endfunction

  function automatic reply_t cache_apply(logic [2:0] op, logic [KEY_BITS-1:0] k,
                                         logic [VALUE_BITS-1:0] v,
                                         logic [LIFETIME_BITS-1:0] ttl);
    reply_t r;
    int s;
    r = '0;
    s = lookup(k);
    case (op)
      OP_GET: begin
        if (s >= 0 && sh_expiry[s] >= sh_now) begin
          promote(s);
          r.found = 1'b1;
          r.value = sh_value[s];
          if (sh_hits != '1) sh_hits++;
        end else if (sh_misses != '1) sh_misses++;
      end
      OP_SET: begin
        if (ttl == '0) ttl = sh_def_ttl;
        if (s < 0) begin
          if (held() >= SLOTS) drop_oldest();
          for (int i = 0; i < SLOTS && s < 0; i++) if (!sh_valid[i]) s = i;
          for (int i = 0; i < SLOTS; i++) if (sh_valid[i]) sh_rank[i]++;
          sh_valid[s] = 1'b1;
          sh_rank[s] = 0;
        end else begin
          promote(s);
        end
        sh_key[s] = k;
        sh_value[s] = v;
        sh_expiry[s] = add_time(sh_now, ttl);
        while (held() > sh_capacity && held() > 0) drop_oldest();
      end
      OP_DELETE: if (s >= 0) drop_slot(s);
      OP_EXISTS: if (s >= 0 && sh_expiry[s] >= sh_now) r.found = 1'b1;
      OP_CLEAN: begin
        for (int i = 0; i < SLOTS; i++)
          if (sh_valid[i] && sh_expiry[i] < sh_now) drop_slot(i);
      end
      OP_TICK: sh_now = add_time(sh_now, 24'd1);
      default: ;
    endcase
    r.count = 5'(held());
    r.hits = sh_hits;
    r.misses = sh_misses;
    return r;
  endfunction

  task automatic send_request(logic [2:0] op, logic [KEY_BITS-1:0] k,
                              logic [VALUE_BITS-1:0] v, logic [LIFETIME_BITS-1:0] ttl,
                              bit chk, logic f, logic [VALUE_BITS-1:0] rv);
    reply_t r;
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_opcode <= op;
    in_lookup_key <= k;
    in_write_value <= v;
    in_lifetime <= ttl;
    do @(posedge clk); while (in_stall);
    r = cache_apply(op, k, v, ttl);
    if (chk && (r.found !== f || r.value !== rv)) begin
      failed = 1;
      mismatches++;
      if (mismatches <= 10)
        $display("directed row mismatch: op %0d exp f%0b v%h got f%0b v%h",
                 op, f, rv, r.found, r.value);
    end
    expected_replies.push_back(r);
  endtask

  task automatic write_reg(logic idx, logic [CFG_BITS-1:0] d);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_CAPACITY) sh_capacity = d[CAP_BITS-1:0];
    else sh_def_ttl = d[LIFETIME_BITS-1:0];
    @(posedge clk);
  endtask

  task automatic drain();
    int guard = 0;
    in_valid <= 1'b0;
    while (expected_replies.size() > 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
    repeat (40) @(posedge clk);
  endtask

  // result checking
  always @(posedge clk) begin
    reply_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_replies.size() == 0) begin
        failed = 1;
        mismatches++;
        if (mismatches <= 10) $display("unexpected result count %0d", out_entry_count);
      end else begin
        exp_r = expected_replies.pop_front();
        if (out_found !== exp_r.found || out_read_value !== exp_r.value ||
            out_entry_count !== exp_r.count || out_hit_count !== exp_r.hits ||
            out_miss_count !== exp_r.misses) begin
          failed = 1;
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch exp f%0b v%h n%0d h%0d m%0d got f%0b v%h n%0d h%0d m%0d",
                     exp_r.found, exp_r.value, exp_r.count, exp_r.hits, exp_r.misses,
                     out_found, out_read_value, out_entry_count, out_hit_count,
                     out_miss_count);
        end
      end
    end
  end

  // receiver stall
  always @(posedge clk) begin
    out_stall <= hold_off || (stall_pct > 0 && $urandom_range(99) < stall_pct);
  end

  // watchdog
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  step_t rows[$];

  function automatic step_t mk(logic [2:0] op, logic [KEY_BITS-1:0] k,
                               logic [VALUE_BITS-1:0] v, logic [LIFETIME_BITS-1:0] t,
                               bit c = 1'b0, logic f = 1'b0,
                               logic [VALUE_BITS-1:0] rv = '0);
    step_t s;
    s.op = op; s.key = k; s.value = v; s.ttl = t;
    s.check_found = c; s.found = f; s.rvalue = rv;
    return s;
  endfunction

  task automatic random_phase(int n);
    logic [2:0] op;
    logic [KEY_BITS-1:0] k;
    logic [LIFETIME_BITS-1:0] t;
    int pick;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      if (pick < 30) op = OP_SET;
      else if (pick < 60) op = OP_GET;
      else if (pick < 70) op = OP_EXISTS;
      else if (pick < 78) op = OP_DELETE;
      else if (pick < 83) op = OP_CLEAN;
      else if (pick < 97) op = OP_TICK;
      else op = $urandom_range(1) ? OP_SPARE6 : OP_SPARE7;
      if ($urandom_range(9) < 8) k = key_pool[$urandom_range(7)];
      else k = {$urandom, $urandom};
      case ($urandom_range(3))
        0: t = '0;
        1: t = LIFETIME_BITS'($urandom_range(4));
        2: t = LIFETIME_BITS'($urandom_range(30));
        default: t = LIFETIME_BITS'($urandom);
      endcase
      send_request(op, k, {$urandom, $urandom}, t, 1'b0, 1'b0, '0);
    end
  endtask

  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      sh_valid[i] = 0; sh_key[i] = 0; sh_value[i] = 0; sh_expiry[i] = 0; sh_rank[i] = 0;
    end
    sh_now = 0; sh_hits = 0; sh_misses = 0;
    sh_capacity = CAP_RESET;
    sh_def_ttl = TTL_RESET;
    for (int i = 0; i < 8; i++) key_pool[i] = {$urandom, $urandom};
    key_pool[0] = '0;
    key_pool[1] = '1;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed rows
    rows.push_back(mk(OP_GET, '0, '0, '0, 1'b1, 1'b0, '0));
    rows.push_back(mk(OP_EXISTS, '1, '0, '0, 1'b1, 1'b0, '0));
    rows.push_back(mk(OP_SET, '0, '1, '0));
    rows.push_back(mk(OP_SET, '1, 64'h0123_4567_89ab_cdef, 24'hffffff));
    rows.push_back(mk(OP_GET, '0, '0, '0, 1'b1, 1'b1, '1));
    rows.push_back(mk(OP_GET, '1, '0, '0, 1'b1, 1'b1, 64'h0123_4567_89ab_cdef));
    rows.push_back(mk(OP_SET, 64'h5, 64'h55, 24'd1));
    rows.push_back(mk(OP_TICK, '0, '0, '0));
    rows.push_back(mk(OP_TICK, '0, '0, '0));
    rows.push_back(mk(OP_EXISTS, 64'h5, '0, '0, 1'b1, 1'b0, '0));
    rows.push_back(mk(OP_GET, 64'h5, '0, '0, 1'b1, 1'b0, '0));
    rows.push_back(mk(OP_CLEAN, '0, '0, '0));
    rows.push_back(mk(OP_DELETE, '1, '0, '0));
    rows.push_back(mk(OP_DELETE, 64'h77, '0, '0));
    rows.push_back(mk(OP_SPARE6, '1, '1, '1, 1'b1, 1'b0, '0));
    rows.push_back(mk(OP_SPARE7, '0, '0, '0, 1'b1, 1'b0, '0));
    for (int i = 0; i < 18; i++) rows.push_back(mk(OP_SET, 64'h100 + 64'(i), 64'(i), '0));
    rows.push_back(mk(OP_GET, 64'h100, '0, '0, 1'b1, 1'b0, '0));
    rows.push_back(mk(OP_GET, 64'h111, '0, '0, 1'b1, 1'b1, 64'd17));
    foreach (rows[i])
      send_request(rows[i].op, rows[i].key, rows[i].value, rows[i].ttl,
                   rows[i].check_found, rows[i].found, rows[i].rvalue);
    drain();

    // small capacity, zero default lifetime
    write_reg(CFG_CAPACITY, 24'd1);
    write_reg(CFG_DEF_TTL, 24'd0);
    send_idle_pct = 0; stall_pct = 0;
    random_phase(120);
    drain();

    write_reg(CFG_CAPACITY, 24'd0);
    write_reg(CFG_DEF_TTL, 24'hffffff);
    send_idle_pct = 68; stall_pct = 0;
    random_phase(100);
    drain();

    write_reg(CFG_CAPACITY, 24'd4);
    write_reg(CFG_DEF_TTL, 24'd3);
    send_idle_pct = 0; stall_pct = 68;
    random_phase(180);
    drain();

    write_reg(CFG_CAPACITY, 24'd31);
    write_reg(CFG_DEF_TTL, 24'd1);
    send_idle_pct = 6; stall_pct = 6;
    random_phase(180);

    // long receiver hold-off while requests keep coming
    fork
      begin
        hold_off = 1;
        repeat (300) @(posedge clk);
        hold_off = 0;
      end
      random_phase(30);
    join
    drain();

    write_reg(CFG_CAPACITY, 24'd16);
    write_reg(CFG_DEF_TTL, 24'd86400);
    send_idle_pct = 0; stall_pct = 0;
    random_phase(200);
    drain();

    if (failed || expected_replies.size() != 0) begin
      $display("tb: failure");
    end else begin
      $display("tb: success");
    end
    $finish;
  end

endmodule
